FILE: rtl/core/lnw_pkg.sv
// Shared types, constants and helpers for the LCD number write sequencer.
`default_nettype none

package lnw_pkg;

    // Sizing
    localparam int MAX_DIGITS  = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CONV_W      = $clog2(VALUE_WIDTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request opcodes
    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_SDEC = 3'd2;
    localparam logic [2:0] OP_HEX  = 3'd3;
    localparam logic [2:0] OP_BIN  = 3'd4;

    // Display lines that take a cursor command
    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    // Bus byte constants
    localparam logic [7:0] CURSOR_BASE  = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_PLUS   = 8'h2B;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_DEC,
        KIND_HEX,
        KIND_BIN
    } lnw_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CURSOR,
        ST_SIGN,
        ST_CHAR,
        ST_DIGIT
    } lnw_state_t;

    // One classified request as it waits in the queue
    typedef struct packed {
        logic                   has_cursor;
        logic [7:0]             cursor_byte;
        lnw_kind_t              kind;
        logic                   has_sign;
        logic                   neg;
        logic [7:0]             char_byte;
        logic [VALUE_WIDTH-1:0] mag;
        logic [CNT_W-1:0]       count;
    } lnw_req_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } lnw_qstat_t;

    // Map one digit to its ASCII code
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] dw;
        dw = {4'b0000, d};
        if (d < 4'd10)
            return ASCII_ZERO + dw;
        else
            return ASCII_A + dw - 8'd10;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcd_number_write_sequencer.sv
// Top level of the LCD number write sequencer: front end, queue and back end.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   request  | req_valid/req_stall, opcode, line, column,     | in
//            | value, character, digit_count                  |
//   write    | wr_valid/wr_stall, is_data, bus_byte, last     | out
//
// A request leaves the queue, then the back end issues one bus write per cycle
// while wr_stall is low (up to 18 writes). Decimal requests first pass through
// the shift-and-add-3 BCD converter before their writes.
// The two-entry queue keeps taking requests while the back end works.
// rst_n clears the queue and the sequencer at once; wr_stall holds the
// output register and the sequencer waits on it.
`default_nettype none

module lcd_number_write_sequencer
    import lnw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [1:0]  line,
    input  wire logic [5:0]  column,
    input  wire logic [15:0] value,
    input  wire logic [7:0]  character,
    input  wire logic [4:0]  digit_count,
    output logic             wr_valid,
    input  wire logic        wr_stall,
    output logic             is_data,
    output logic [7:0]       bus_byte,
    output logic             last
);

    lnw_qstat_t qstat;
    lnw_req_t   push_data;
    lnw_req_t   head;
    logic       push;
    logic       pop;

    lnw_front u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .line        (line),
        .column      (column),
        .value       (value),
        .character   (character),
        .digit_count (digit_count),
        .qstat       (qstat),
        .push        (push),
        .push_data   (push_data)
    );

    lnw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    lnw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .is_data  (is_data),
        .bus_byte (bus_byte),
        .last     (last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lnw_front.sv
// Front end: accept requests, classify them and push them into the queue.
`default_nettype none

module lnw_front
    import lnw_pkg::*;
(
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [2:0]       opcode,
    input  wire logic [1:0]       line,
    input  wire logic [5:0]       column,
    input  wire logic [15:0]      value,
    input  wire logic [7:0]       character,
    input  wire logic [4:0]       digit_count,
    input  wire lnw_qstat_t       qstat,
    output logic                  push,
    output lnw_req_t              push_data
);

    logic [VALUE_WIDTH+15:0] value_pad;
    logic [VALUE_WIDTH-1:0]  v;
    logic [7:0]              col_m1;
    logic                    known_op;
    logic                    empty_req;

    // Take the value at the working width
    assign value_pad = {{VALUE_WIDTH{1'b0}}, value};
    assign v         = value_pad[VALUE_WIDTH-1:0];
    assign col_m1    = {2'b00, column} - 8'd1;

    // Classify the request
    always_comb
    begin
        push_data.has_cursor  = (line == LINE_ONE) || (line == LINE_TWO);
        push_data.cursor_byte = CURSOR_BASE |
                                ((line == LINE_TWO) ? (col_m1 + LINE2_OFFSET) : col_m1);
        push_data.char_byte   = character;
        push_data.has_sign    = (opcode == OP_SDEC);
        push_data.neg         = (opcode == OP_SDEC) && v[VALUE_WIDTH-1];
        push_data.mag         = push_data.neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
        if (int'(digit_count) > MAX_DIGITS)
            push_data.count = CNT_W'(MAX_DIGITS);
        else
            push_data.count = CNT_W'(digit_count);
        known_op = 1'b1;
        unique case (opcode)
            OP_CHAR: push_data.kind = KIND_CHAR;
            OP_UDEC: push_data.kind = KIND_DEC;
            OP_SDEC: push_data.kind = KIND_DEC;
            OP_HEX:  push_data.kind = KIND_HEX;
            OP_BIN:  push_data.kind = KIND_BIN;
            default:
            begin
                push_data.kind = KIND_CHAR;
                known_op       = 1'b0;
            end
        endcase
    end

    // Drop requests that cause no write at all
    assign empty_req = !push_data.has_cursor && (opcode != OP_CHAR) &&
                       (opcode != OP_SDEC) && (push_data.count == '0);

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full && known_op && !empty_req;

endmodule

`default_nettype wire

FILE: rtl/core/lnw_queue.sv
// Short request queue between the front end and the write sequencer.
`default_nettype none

module lnw_queue
    import lnw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire lnw_req_t push_data,
    input  wire logic     pop,
    output lnw_req_t      head,
    output lnw_qstat_t    qstat
);

    lnw_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qstat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: rtl/core/lnw_back.sv
// Back end: convert digits and sequence the bus writes of one request.
`default_nettype none

module lnw_back
    import lnw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lnw_req_t   head,
    input  wire lnw_qstat_t qstat,
    output logic            pop,
    output logic            wr_valid,
    input  wire logic       wr_stall,
    output logic            is_data,
    output logic [7:0]      bus_byte,
    output logic            last
);

    typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

    lnw_state_t             state_reg, state_next;
    lnw_req_t               req_reg, req_next;
    digits_t                dig_reg, dig_next;
    digits_t                dig_adj;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [CONV_W-1:0]      conv_cnt_reg, conv_cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   is_data_reg, is_data_next;
    logic [7:0]             bus_byte_reg, bus_byte_next;
    logic                   last_reg, last_next;

    logic [4*MAX_DIGITS+VALUE_WIDTH-1:0] hex_pad;
    logic [MAX_DIGITS+VALUE_WIDTH-1:0]   bin_pad;
    logic                                out_free;
    logic                                emit;

    // First write of a request
    function automatic lnw_state_t first_step(input lnw_req_t r);
        if (r.has_cursor)
            return ST_CURSOR;
        else if (r.kind == KIND_CHAR)
            return ST_CHAR;
        else if (r.has_sign)
            return ST_SIGN;
        else
            return ST_DIGIT;
    endfunction

    // Write that follows the cursor command
    function automatic lnw_state_t after_cursor(input lnw_req_t r);
        if (r.kind == KIND_CHAR)
            return ST_CHAR;
        else if (r.has_sign)
            return ST_SIGN;
        else if (r.count != '0)
            return ST_DIGIT;
        else
            return ST_IDLE;
    endfunction

    assign out_free = !out_valid_reg || !wr_stall;
    assign pop      = (state_reg == ST_IDLE) && !qstat.empty;
    assign hex_pad  = {{(4*MAX_DIGITS){1'b0}}, head.mag};
    assign bin_pad  = {{MAX_DIGITS{1'b0}}, head.mag};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                    state_next = (head.kind == KIND_DEC) ? ST_CONV : first_step(head);
            end
            ST_CONV:
            begin
                if (conv_cnt_reg == '0)
                    state_next = first_step(req_reg);
            end
            ST_CURSOR:
            begin
                if (out_free)
                    state_next = after_cursor(req_reg);
            end
            ST_SIGN:
            begin
                if (out_free)
                    state_next = (req_reg.count != '0) ? ST_DIGIT : ST_IDLE;
            end
            ST_CHAR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_DIGIT:
            begin
                if (out_free && (idx_reg == '0))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Add-3 adjust of every BCD digit before the shift
    always_comb
    begin
        for (int j = 0; j < MAX_DIGITS; j++)
            dig_adj[j] = (dig_reg[j] >= 4'd5) ? (dig_reg[j] + 4'd3) : dig_reg[j];
    end

    // Load requests, run the binary to BCD shifts, step the digit index
    always_comb
    begin
        req_next      = req_reg;
        dig_next      = dig_reg;
        mag_next      = mag_reg;
        conv_cnt_next = conv_cnt_reg;
        idx_next      = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    req_next      = head;
                    mag_next      = head.mag;
                    conv_cnt_next = CONV_W'(VALUE_WIDTH - 1);
                    idx_next      = IDX_W'(head.count - 1'b1);
                    unique case (head.kind)
                        KIND_HEX: dig_next = hex_pad[4*MAX_DIGITS-1:0];
                        KIND_BIN:
                        begin
                            for (int j = 0; j < MAX_DIGITS; j++)
                                dig_next[j] = {3'b000, bin_pad[j]};
                        end
                        default: dig_next = '0;
                    endcase
                end
            end
            ST_CONV:
            begin
                dig_next      = digits_t'({dig_adj, mag_reg[VALUE_WIDTH-1]});
                mag_next      = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                conv_cnt_next = conv_cnt_reg - 1'b1;
            end
            ST_DIGIT:
            begin
                if (out_free && (idx_reg != '0))
                    idx_next = idx_reg - 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Build the write of the current step
    always_comb
    begin
        emit          = 1'b0;
        is_data_next  = is_data_reg;
        bus_byte_next = bus_byte_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_CURSOR:
            begin
                emit          = out_free;
                is_data_next  = 1'b0;
                bus_byte_next = req_reg.cursor_byte;
                last_next     = (req_reg.kind != KIND_CHAR) && !req_reg.has_sign &&
                                (req_reg.count == '0);
            end
            ST_SIGN:
            begin
                emit          = out_free;
                is_data_next  = 1'b1;
                bus_byte_next = req_reg.neg ? ASCII_MINUS : ASCII_PLUS;
                last_next     = (req_reg.count == '0);
            end
            ST_CHAR:
            begin
                emit          = out_free;
                is_data_next  = 1'b1;
                bus_byte_next = req_reg.char_byte;
                last_next     = 1'b1;
            end
            ST_DIGIT:
            begin
                emit          = out_free;
                is_data_next  = 1'b1;
                bus_byte_next = digit_char(dig_reg[idx_reg]);
                last_next     = (idx_reg == '0);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // Hold the waiting write until it is taken
        if (!emit)
        begin
            is_data_next  = is_data_reg;
            bus_byte_next = bus_byte_reg;
            last_next     = last_reg;
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (!wr_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        dig_reg      <= dig_next;
        mag_reg      <= mag_next;
        conv_cnt_reg <= conv_cnt_next;
        idx_reg      <= idx_next;
        is_data_reg  <= is_data_next;
        bus_byte_reg <= bus_byte_next;
        last_reg     <= last_next;
    end

    assign wr_valid = out_valid_reg;
    assign is_data  = is_data_reg;
    assign bus_byte = bus_byte_reg;
    assign last     = last_reg;

`ifndef SYNTHESIS
    a_conv_only_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> req_reg.kind == KIND_DEC)
        else $error("BCD conversion running for a non-decimal request");

    a_digits_need_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> req_reg.count != '0)
        else $error("digit step entered with zero digit count");

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && conv_cnt_reg == '0) |=> state_reg != ST_CONV)
        else $error("BCD conversion overran its shift count");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !qstat.empty) |=> state_reg != ST_IDLE)
        else $error("popped request did not start a sequence");
`endif

endmodule

`default_nettype wire
